// ----- src/scfr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sector chain file reader: opcodes, status codes, sequencer states,
// disk geometry constants and the zone table functions.
// No dependencies.
package scfr_pkg;

	// Image size in bytes and the longest chain followed before the file is cut
	localparam logic [17:0] IMAGE_BYTES       = 18'd174848;
	localparam logic [10:0] MAX_CHAIN_SECTORS = 11'd1024;
	localparam logic [7:0]  PAYLOAD_BYTES     = 8'd254;
	localparam logic [7:0]  NUM_TRACKS        = 8'd35;

	// Byte offsets of the link bytes and of the first payload byte in a sector
	localparam logic [7:0] OFS_LINK_TRACK  = 8'd0;
	localparam logic [7:0] OFS_LINK_SECTOR = 8'd1;
	localparam logic [7:0] OFS_PAYLOAD     = 8'd2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_OPEN  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_SECTOR_FAIL = 2'd1,
		ST_EMPTY       = 2'd2,
		ST_NOT_OPEN    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LINK_T,
		S_LINK_S,
		S_DATA,
		S_NEXT_T,
		S_NEXT_S,
		S_RESP
	} state_t;

	// Sector address check and linear sector index
	typedef struct packed {
		logic       ok;
		logic [9:0] idx;
	} geom_t;

	// Sectors on a track, zero for a track outside the disk
	function automatic logic [4:0] track_sectors(input logic [7:0] t);
		logic [4:0] n;
		if (t == 8'd0) begin
			n = 5'd0;
		end else if (t <= 8'd17) begin
			n = 5'd21;
		end else if (t <= 8'd24) begin
			n = 5'd19;
		end else if (t <= 8'd30) begin
			n = 5'd18;
		end else if (t <= NUM_TRACKS) begin
			n = 5'd17;
		end else begin
			n = 5'd0;
		end
		return n;
	endfunction

	// Index of the first sector of a track; meaningful for tracks 1 to 35
	function automatic logic [9:0] zone_first(input logic [7:0] t);
		logic [9:0] tt;
		logic [9:0] f;
		tt = {2'b00, t};
		if (t <= 8'd17) begin
			f = 10'((tt - 10'd1) * 10'd21);
		end else if (t <= 8'd24) begin
			f = 10'(10'd357 + (tt - 10'd18) * 10'd19);
		end else if (t <= 8'd30) begin
			f = 10'(10'd490 + (tt - 10'd25) * 10'd18);
		end else begin
			f = 10'(10'd598 + (tt - 10'd31) * 10'd17);
		end
		return f;
	endfunction

endpackage

// ----- src/scfr_geom.sv -----
`timescale 1ns / 1ps
// Sector address mapper: checks a track/sector pair against the zone table and
// gives the linear sector index. Depends on scfr_pkg.
module scfr_geom (
	input  logic [7:0]     track,
	input  logic [7:0]     sector,
	output scfr_pkg::geom_t geom
);
	import scfr_pkg::*;

	logic [4:0] count;

	// Look up the zone, check the sector and add it to the zone base
	always_comb begin
		count    = track_sectors(track);
		geom.ok  = (count != 5'd0) && (sector < {3'b000, count});
		geom.idx = 10'(zone_first(track) + {2'b00, sector});
	end

endmodule

// ----- src/sector_chain_file_reader.sv -----
`timescale 1ns / 1ps
// Sector chain file reader: top level with the image memory and the read sequencer.
// Depends on scfr_pkg and scfr_geom.
//
// Usage: requests enter on in_valid/in_ready with opcode and its operands; each
// request gives exactly one result on out_valid/out_ready (read_data, data_valid,
// end_of_file, status). A write request stores image_byte at image_address, an open
// request starts a file at start_track/start_sector, a read request returns the next
// payload byte of the open file.
// From accept to result: write, open and rejected reads go straight to the result
// state; a read inside a sector first reads its payload byte; a read that first enters
// a sector reads the two link bytes before the payload byte, and one that returns the
// last byte of a non-final sector then reads the link bytes again for the next sector.
// The image memory, one registered read per cycle beside one write, sets these
// steps; one request is in work at a time.
// A finished result sits in the output register; the next request is accepted as soon
// as that result is loaded there, and a stalled receiver only holds back the load.
// Reset clears all file state and closes the file; the image memory is not cleared and
// reads of never-written bytes give undefined data.
module sector_chain_file_reader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [17:0] image_address,
	input  logic [7:0]  image_byte,
	input  logic [7:0]  start_track,
	input  logic [7:0]  start_sector,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        data_valid,
	output logic        end_of_file,
	output logic [1:0]  status
);
	import scfr_pkg::*;

	state_t      state_q, state_d;
	logic [7:0]  cur_track_q, cur_sector_q;
	logic [7:0]  pos_q, bis_q;
	logic        final_q, link_pending_q, file_open_q, any_q;
	logic [10:0] chain_q;
	logic [9:0]  base_q;

	logic [7:0]  res_data_q;
	logic        res_valid_q, res_eof_q;
	logic [1:0]  res_status_q;

	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        out_dvalid_q, out_eof_q;
	logic [1:0]  out_status_q;

	logic [7:0]  mem [IMAGE_BYTES];
	logic [7:0]  rd_q;
	logic [17:0] raddr;
	logic        mem_we;

	logic        accept, out_load;
	geom_t       geom;
	logic [7:0]  ls_len, link_bis, pos_inc;
	logic        last_byte, chain_full, chain_ends;
	logic [1:0]  eof_status;

	scfr_geom u_geom (
		.track  (cur_track_q),
		.sector (cur_sector_q),
		.geom   (geom)
	);

	assign accept     = in_valid && in_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign out_load   = (state_q == S_RESP) && (!out_valid_q || out_ready);
	assign mem_we     = accept && (opcode == OP_WRITE) && (image_address < IMAGE_BYTES);

	assign ls_len     = (rd_q == 8'd0) ? 8'd0 : 8'(rd_q - 8'd1);
	assign link_bis   = final_q ? ls_len : PAYLOAD_BYTES;
	assign pos_inc    = 8'(pos_q + 8'd1);
	assign last_byte  = (pos_inc >= bis_q);
	assign chain_full = (chain_q >= MAX_CHAIN_SECTORS);
	assign chain_ends = last_byte && (final_q || chain_full);
	assign eof_status = any_q ? ST_OK : ST_EMPTY;

	// Image memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[image_address] <= image_byte;
		end
		rd_q <= mem[raddr];
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory read address
	always_comb begin
		state_d = state_q;
		raddr   = {base_q, OFS_LINK_TRACK};
		unique case (state_q)
			S_IDLE: begin
				if (link_pending_q) begin
					raddr = {geom.idx, OFS_LINK_TRACK};
				end else begin
					raddr = {geom.idx, 8'(pos_q + OFS_PAYLOAD)};
				end
				if (accept) begin
					state_d = S_RESP;
					if (opcode == OP_READ && file_open_q && geom.ok) begin
						if (link_pending_q) begin
							state_d = S_LINK_T;
						end else if (pos_q < bis_q) begin
							state_d = S_DATA;
						end
					end
				end
			end
			S_LINK_T: begin
				raddr   = {base_q, OFS_LINK_SECTOR};
				state_d = S_LINK_S;
			end
			S_LINK_S: begin
				raddr   = {base_q, OFS_PAYLOAD};
				state_d = (link_bis == 8'd0) ? S_RESP : S_DATA;
			end
			S_DATA: begin
				raddr   = {base_q, OFS_LINK_TRACK};
				state_d = (last_byte && !chain_ends) ? S_NEXT_T : S_RESP;
			end
			S_NEXT_T: begin
				raddr   = {base_q, OFS_LINK_SECTOR};
				state_d = S_NEXT_S;
			end
			S_NEXT_S: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// File state: open, follow links, advance position, close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_track_q    <= '0;
			cur_sector_q   <= '0;
			pos_q          <= '0;
			bis_q          <= '0;
			final_q        <= 1'b0;
			link_pending_q <= 1'b0;
			chain_q        <= '0;
			file_open_q    <= 1'b0;
			any_q          <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && opcode == OP_OPEN) begin
						cur_track_q    <= start_track;
						cur_sector_q   <= start_sector;
						pos_q          <= '0;
						bis_q          <= '0;
						final_q        <= 1'b0;
						link_pending_q <= 1'b1;
						chain_q        <= '0;
						file_open_q    <= 1'b1;
						any_q          <= 1'b0;
					end else if (accept && opcode == OP_READ && file_open_q) begin
						if (!geom.ok || (!link_pending_q && pos_q >= bis_q)) begin
							file_open_q    <= 1'b0;
							link_pending_q <= 1'b0;
						end
					end
				end
				S_LINK_T: begin
					final_q <= (rd_q == 8'd0);
					chain_q <= 11'(chain_q + 11'd1);
				end
				S_LINK_S: begin
					bis_q          <= link_bis;
					pos_q          <= '0;
					link_pending_q <= 1'b0;
					if (link_bis == 8'd0) begin
						file_open_q <= 1'b0;
					end
				end
				S_DATA: begin
					any_q <= 1'b1;
					pos_q <= pos_inc;
					if (chain_ends) begin
						file_open_q    <= 1'b0;
						link_pending_q <= 1'b0;
					end
				end
				S_NEXT_T: begin
					cur_track_q <= rd_q;
				end
				S_NEXT_S: begin
					cur_sector_q   <= rd_q;
					link_pending_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Sector base and result fields of the request in work
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				base_q       <= geom.idx;
				res_data_q   <= '0;
				res_valid_q  <= 1'b0;
				res_eof_q    <= 1'b0;
				res_status_q <= ST_OK;
				if (opcode == OP_READ) begin
					if (!file_open_q) begin
						res_status_q <= ST_NOT_OPEN;
					end else if (!geom.ok) begin
						res_status_q <= ST_SECTOR_FAIL;
					end else if (!link_pending_q && pos_q >= bis_q) begin
						res_eof_q    <= 1'b1;
						res_status_q <= eof_status;
					end
				end
			end
			S_LINK_S: begin
				if (link_bis == 8'd0) begin
					res_eof_q    <= 1'b1;
					res_status_q <= eof_status;
				end
			end
			S_DATA: begin
				res_data_q  <= rd_q;
				res_valid_q <= 1'b1;
				res_eof_q   <= chain_ends;
			end
			default: begin
			end
		endcase
	end

	// Output register: load a finished result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= res_data_q;
			out_dvalid_q <= res_valid_q;
			out_eof_q    <= res_eof_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_data_q;
	assign data_valid  = out_dvalid_q;
	assign end_of_file = out_eof_q;
	assign status      = out_status_q;

	// A pending link fetch only exists for an open file
	a_link_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		link_pending_q |-> file_open_q)
		else $error("link pending with no file open");

	// A payload fetch always lies inside the sector's payload
	a_data_in_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) |-> (pos_q < bis_q))
		else $error("payload read beyond sector length");

	// Between reads of an open file the position stays inside the sector
	a_idle_position: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && file_open_q && !link_pending_q) |-> (pos_q < bis_q))
		else $error("open file parked at end of sector");

	// A result loaded with a payload byte carries ok status
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (!data_valid || status == ST_OK))
		else $error("payload byte with error status");

endmodule

// ----- verif/sector_chain_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the sector chain file reader: watches both channels, predicts
// the result of every accepted request and compares it with what the block returns.
// Depends on scfr_pkg for opcodes, status codes and disk geometry constants.
module sector_chain_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [17:0] image_address,
	input  logic [7:0]  image_byte,
	input  logic [7:0]  start_track,
	input  logic [7:0]  start_sector,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  read_data,
	input  logic        data_valid,
	input  logic        end_of_file,
	input  logic [1:0]  status,
	output int          errors,
	output int          pending
);
	import scfr_pkg::*;

	localparam int SECTOR_BYTES = 256;
	localparam int DISK_BYTES   = int'(IMAGE_BYTES);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       eof;
		status_t    status;
	} reply_t;

	// Shadow disk image and file position
	logic [7:0] disk [DISK_BYTES];
	logic [7:0] at_track;
	logic [7:0] at_sector;
	logic [7:0] byte_idx;
	logic [7:0] sector_len;
	logic       in_last;
	logic       link_due;
	logic [10:0] hops;
	logic       is_open;
	logic       gave_byte;

	reply_t replies_due [$];

	// Sectors on a track, zero off the disk
	function automatic int sectors_on(input logic [7:0] t);
		if (t == 8'd0 || t > NUM_TRACKS) return 0;
		if (t <= 8'd17) return 21;
		if (t <= 8'd24) return 19;
		if (t <= 8'd30) return 18;
		return 17;
	endfunction

	// Byte offset of a sector in the image, -1 for a bad address
	function automatic int sector_base(input logic [7:0] t, input logic [7:0] s);
		int first;
		first = 0;
		if (int'(s) >= sectors_on(t)) return -1;
		for (int k = 1; k < int'(t); k++) first += sectors_on(8'(k));
		return (first + int'(s)) * SECTOR_BYTES;
	endfunction

	// Apply one request to the shadow state and form its result
	task automatic next_reply(input opcode_t op, input logic [17:0] addr,
			input logic [7:0] value, input logic [7:0] t, input logic [7:0] s,
			output reply_t r);
		int base;
		r = '0;
		case (op)
		OP_WRITE: begin
			if (addr < IMAGE_BYTES) disk[addr] = value;
		end
		OP_OPEN: begin
			at_track = t;
			at_sector = s;
			byte_idx = 8'd0;
			sector_len = 8'd0;
			in_last = 1'b0;
			link_due = 1'b1;
			hops = '0;
			is_open = 1'b1;
			gave_byte = 1'b0;
		end
		OP_READ: begin
			base = sector_base(at_track, at_sector);
			if (!is_open) begin
				r.status = ST_NOT_OPEN;
			end else if (base < 0) begin
				// drop the file on a sector outside the disk
				is_open = 1'b0;
				link_due = 1'b0;
				r.status = ST_SECTOR_FAIL;
			end else begin
				// load the link bytes when entering a sector
				if (link_due) begin
					hops = hops + 11'd1;
					in_last = (disk[base + OFS_LINK_TRACK] == 8'd0);
					if (in_last) begin
						sector_len = (disk[base + OFS_LINK_SECTOR] != 8'd0) ?
							disk[base + OFS_LINK_SECTOR] - 8'd1 : 8'd0;
					end else begin
						sector_len = PAYLOAD_BYTES;
					end
					byte_idx = 8'd0;
					link_due = 1'b0;
				end
				if (byte_idx >= sector_len) begin
					// final sector with nothing in it
					r.eof = 1'b1;
					r.status = gave_byte ? ST_OK : ST_EMPTY;
					is_open = 1'b0;
					link_due = 1'b0;
				end else begin
					r.data = disk[base + OFS_PAYLOAD + byte_idx];
					r.valid = 1'b1;
					gave_byte = 1'b1;
					byte_idx = byte_idx + 8'd1;
					if (byte_idx >= sector_len) begin
						// close at the end of the chain, else follow the link
						if (in_last || hops >= MAX_CHAIN_SECTORS) begin
							r.eof = 1'b1;
							is_open = 1'b0;
							link_due = 1'b0;
						end else begin
							at_track = disk[base + OFS_LINK_TRACK];
							at_sector = disk[base + OFS_LINK_SECTOR];
							link_due = 1'b1;
						end
					end
				end
			end
		end
		default: begin
		end
		endcase
	endtask

	// Compare finished results, then predict for a new request
	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		reply_t made;
		if (!arst_n) begin
			at_track = 8'd0;
			at_sector = 8'd0;
			byte_idx = 8'd0;
			sector_len = 8'd0;
			in_last = 1'b0;
			link_due = 1'b0;
			hops = '0;
			is_open = 1'b0;
			gave_byte = 1'b0;
			replies_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT) begin
						$display("%0t: unexpected result: data %02h valid %0b eof %0b status %0d",
							$time, read_data, data_valid, end_of_file, status);
					end
				end else begin
					want = replies_due.pop_front();
					if (read_data !== want.data || data_valid !== want.valid ||
							end_of_file !== want.eof || status !== want.status) begin
						errors++;
						if (errors <= REPORT_LIMIT) begin
							$display("%0t: expected data %02h valid %0b eof %0b status %0d",
								$time, want.data, want.valid, want.eof, want.status);
							$display("%0t: got      data %02h valid %0b eof %0b status %0d",
								$time, read_data, data_valid, end_of_file, status);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				next_reply(opcode_t'(opcode), image_address, image_byte, start_track,
					start_sector, made);
				replies_due.insert(replies_due.size(), made);
			end
			pending = replies_due.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Top of the sector chain file reader testbench: clock, reset, request stimulus,
// random result stalls, watchdog and verdict. Depends on scfr_pkg,
// sector_chain_file_reader and sector_chain_checker.
module testbench;
	import scfr_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_ITEMS   = 420;
	localparam int CHAIN_AFTER    = 48;
	localparam int IDLE_PERCENT   = 27;
	localparam int CALM_FROM      = 200;
	localparam int CALM_TO        = 330;
	localparam int SECTOR_BYTES   = 256;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode        = OP_NONE;
	logic [17:0] image_address = '0;
	logic [7:0]  image_byte    = '0;
	logic [7:0]  start_track   = '0;
	logic [7:0]  start_sector  = '0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [7:0]  read_data;
	logic        data_valid;
	logic        end_of_file;
	logic [1:0]  status;

	int   errors;
	int   pending;
	int   items_sent   = 0;
	int   quiet_cycles = 0;
	logic calm;
	bit   sector_full [1024];

	sector_chain_file_reader dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.image_address(image_address),
		.image_byte   (image_byte),
		.start_track  (start_track),
		.start_sector (start_sector),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.data_valid   (data_valid),
		.end_of_file  (end_of_file),
		.status       (status)
	);

	sector_chain_checker read_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.image_address(image_address),
		.image_byte   (image_byte),
		.start_track  (start_track),
		.start_sector (start_sector),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.data_valid   (data_valid),
		.end_of_file  (end_of_file),
		.status       (status),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// Hold both sides busy for a stretch in the middle of the run
	assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

	// Stall the result side at random
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Count cycles in which neither channel moves
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request, with an optional gap first, and wait for its acceptance
	task automatic send_request(input opcode_t op, input logic [17:0] addr,
			input logic [7:0] value, input logic [7:0] t, input logic [7:0] s);
		int gap;
		gap = (!calm && $urandom_range(99) < IDLE_PERCENT) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		image_address <= addr;
		image_byte <= value;
		start_track <= t;
		start_sector <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic put_byte(input logic [17:0] addr, input logic [7:0] value);
		send_request(OP_WRITE, addr, value, 8'($urandom), 8'($urandom));
	endtask

	task automatic open_at(input logic [7:0] t, input logic [7:0] s);
		send_request(OP_OPEN, 18'($urandom), 8'($urandom), t, s);
	endtask

	task automatic read_next();
		send_request(OP_READ, 18'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	function automatic int sector_addr(input logic [7:0] t, input logic [7:0] s);
		return (int'(zone_first(t)) + int'(s)) * SECTOR_BYTES;
	endfunction

	// Random sector on the disk, as {track, sector}
	function automatic logic [15:0] valid_place();
		logic [7:0] t;
		t = 8'($urandom_range(1, NUM_TRACKS));
		return {t, 8'($urandom_range(0, track_sectors(t) - 1))};
	endfunction

	// Random sector address off the disk; track zero only when asked
	function automatic logic [15:0] invalid_place(input bit allow_zero);
		logic [7:0] t;
		logic [7:0] s;
		case ($urandom_range(allow_zero ? 2 : 1))
		0: begin
			t = 8'($urandom_range(NUM_TRACKS + 1, 255));
			s = 8'($urandom);
		end
		1: begin
			t = 8'($urandom_range(1, NUM_TRACKS));
			s = 8'($urandom_range(track_sectors(t), 255));
		end
		default: begin
			t = 8'd0;
			s = 8'($urandom);
		end
		endcase
		return {t, s};
	endfunction

	// Second link byte of a final sector: mostly short files, some empty, few long
	function automatic logic [7:0] pick_last_link();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0) return 8'($urandom_range(25, 48));
		if (roll == 1) return 8'($urandom_range(1));
		return 8'($urandom_range(2, 24));
	endfunction

	// Write a final sector: link bytes and exactly the payload that will be read
	task automatic build_final(input logic [15:0] place, input logic [7:0] last_link);
		int base;
		base = sector_addr(place[15:8], place[7:0]);
		put_byte(18'(base + OFS_LINK_TRACK), 8'd0);
		put_byte(18'(base + OFS_LINK_SECTOR), last_link);
		for (int k = OFS_PAYLOAD; k <= int'(last_link); k++) begin
			put_byte(18'(base + k), 8'($urandom));
		end
	endtask

	// Open a file and read it through, with an optional reopen and an optional
	// payload rewrite while it is open; a few reads past the end hit a closed file
	task automatic run_file(input logic [15:0] place, input int span, input int poke_base,
			input int poke_hi);
		int reopen_at;
		int poke_at;
		int reads;
		reopen_at = ($urandom_range(4) == 0) ? $urandom_range(0, span - 1) : -1;
		poke_at = (poke_hi >= OFS_PAYLOAD && $urandom_range(2) == 0) ?
			$urandom_range(0, span - 1) : -1;
		open_at(place[15:8], place[7:0]);
		reads = span + $urandom_range(0, 2);
		for (int i = 0; i < reads; i++) begin
			if (i == poke_at) begin
				put_byte(18'(poke_base + $urandom_range(OFS_PAYLOAD, poke_hi)), 8'($urandom));
			end
			if (i == reopen_at) begin
				open_at(place[15:8], place[7:0]);
				reads = i + span + $urandom_range(0, 2);
			end
			read_next();
		end
	endtask

	initial begin : stimulus
		logic [15:0] head;
		logic [15:0] tail;
		logic [7:0]  last_link;
		int          first_random;
		int          chains_run;
		int          pick;
		int          base;
		int          tail_len;
		chains_run = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// read with no file, unused opcode, writes at and past the image end
		read_next();
		send_request(OP_NONE, 18'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		put_byte(18'h3FFFF, 8'hAA);
		put_byte(IMAGE_BYTES, 8'h55);
		put_byte(IMAGE_BYTES - 18'd1, 8'h00);

		// bad sector addresses at both sides of the disk
		open_at(8'd0, 8'd0);
		read_next();
		open_at(NUM_TRACKS + 8'd1, 8'd0);
		read_next();
		open_at(NUM_TRACKS, 8'(track_sectors(NUM_TRACKS)));
		read_next();
		open_at(8'hFF, 8'hFF);
		read_next();

		// empty files: length byte zero, then one
		build_final({8'd1, 8'd0}, 8'd0);
		open_at(8'd1, 8'd0);
		read_next();
		put_byte(18'(OFS_LINK_SECTOR), 8'd1);
		open_at(8'd1, 8'd0);
		read_next();

		// one byte file in the last sector of the disk, then a read past its end
		head = {NUM_TRACKS, 8'(track_sectors(NUM_TRACKS) - 5'd1)};
		base = sector_addr(head[15:8], head[7:0]);
		put_byte(18'(base + OFS_LINK_TRACK), 8'd0);
		put_byte(18'(base + OFS_LINK_SECTOR), 8'd2);
		put_byte(18'(base + OFS_PAYLOAD), 8'hFF);
		open_at(head[15:8], head[7:0]);
		read_next();
		read_next();

		// random files, one chain and noise
		first_random = items_sent;
		while (items_sent - first_random < RANDOM_ITEMS || chains_run < 1) begin
			pick = $urandom_range(99);
			if (chains_run == 0 && (pick < 12 || items_sent - first_random > CHAIN_AFTER)) begin
				// full sector linking on to a short final sector or off the disk
				head = valid_place();
				do tail = valid_place(); while (tail == head);
				base = sector_addr(head[15:8], head[7:0]);
				if (!sector_full[base / SECTOR_BYTES]) begin
					for (int k = OFS_PAYLOAD; k < SECTOR_BYTES; k++) begin
						put_byte(18'(base + k), 8'($urandom));
					end
					sector_full[base / SECTOR_BYTES] = 1'b1;
				end
				if ($urandom_range(3) == 0) begin
					tail = invalid_place(1'b0);
					tail_len = 1;
				end else begin
					last_link = 8'($urandom_range(0, 12));
					build_final(tail, last_link);
					tail_len = (last_link > 8'd1) ? int'(last_link) - 1 : 1;
				end
				put_byte(18'(base + OFS_LINK_TRACK), tail[15:8]);
				put_byte(18'(base + OFS_LINK_SECTOR), tail[7:0]);
				run_file(head, int'(PAYLOAD_BYTES) + tail_len, base, SECTOR_BYTES - 1);
				chains_run++;
			end else if (pick < 70) begin
				// single final sector file
				head = valid_place();
				last_link = pick_last_link();
				build_final(head, last_link);
				run_file(head, (last_link > 8'd1) ? int'(last_link) - 1 : 1,
					sector_addr(head[15:8], head[7:0]), int'(last_link));
			end else begin
				// stray writes, unused opcode, bad opens, reads of a closed file
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(3))
					0: put_byte(18'($urandom), 8'($urandom));
					1: send_request(OP_NONE, 18'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
					2: begin
						tail = invalid_place(1'b1);
						open_at(tail[15:8], tail[7:0]);
						read_next();
					end
					default: read_next();
					endcase
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
